/* hw/rtl/fadq_pkg.sv */
// Package for the frame admission queue: command, result and counter codes,
// fixed field widths and the counter event struct.
// No dependencies.
package fadq_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned CARD_W     = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SESSION_W  = 64;
  localparam int unsigned RESULT_W   = 4;
  localparam int unsigned CNT_IDX_W  = 4;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned NUM_COUNTERS = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_BEGIN = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_READ  = 3'd4
  } fadq_cmd_e;

  typedef enum logic [RESULT_W-1:0] {
    RC_ACCEPTED        = 4'd0,
    RC_DISABLED        = 4'd1,
    RC_FULL            = 4'd2,
    RC_STOPPING        = 4'd3,
    RC_INVALID_FRAME   = 4'd4,
    RC_INVALID_PAYLOAD = 4'd5,
    RC_STALE           = 4'd6,
    RC_NOT_READY       = 4'd7,
    RC_DELIVERED       = 4'd8,
    RC_EMPTY           = 4'd9,
    RC_DONE            = 4'd10
  } fadq_result_e;

  typedef enum logic [CNT_IDX_W-1:0] {
    CNT_ACCEPTED        = 4'd0,
    CNT_DISABLED        = 4'd1,
    CNT_FULL            = 4'd2,
    CNT_STOPPING        = 4'd3,
    CNT_INVALID_FRAME   = 4'd4,
    CNT_INVALID_PAYLOAD = 4'd5,
    CNT_STALE           = 4'd6,
    CNT_NOT_READY       = 4'd7,
    CNT_DEQUEUED        = 4'd8,
    CNT_ATTEMPTS        = 4'd9,
    CNT_FLUSHED         = 4'd10,
    CNT_PEAK            = 4'd11,
    CNT_DELIVERED       = 4'd12
  } fadq_cnt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTAKE_ENABLED = 4'd0,
    CFG_CHANNEL_MASK   = 4'd1,
    CFG_SERVICE_READY  = 4'd2,
    CFG_STOPPING_FLAG  = 4'd3
  } fadq_cfg_e;

  // Statistics events raised by one command
  typedef struct packed {
    logic attempt;
    logic accepted;
    logic disabled;
    logic full;
    logic stopping;
    logic invalid_frame;
    logic invalid_payload;
    logic stale_one;
    logic not_ready_one;
    logic dequeued;
    logic delivered;
    logic flush;
    logic stale_flush;
    logic not_ready_flush;
    logic stopping_flush;
  } fadq_cnt_evt_t;

endpackage

/* hw/rtl/fadq_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module fadq_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then register the read word (old data on a same-address collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/fadq_counters.sv */
// Bank of saturating statistics counters with a peak depth tracker and an
// indexed read mux. Depends on fadq_pkg.
module fadq_counters #(
  parameter int unsigned COUNTER_WIDTH = 32,
  parameter int unsigned DEPTH_W       = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fadq_pkg::fadq_cnt_evt_t          evt_i,
  input  logic [DEPTH_W-1:0]               flush_n_i,
  input  logic [DEPTH_W-1:0]               depth_i,
  input  logic [fadq_pkg::CNT_IDX_W-1:0]   rd_idx_i,
  output logic [COUNTER_WIDTH-1:0]         rd_value_o
);
  import fadq_pkg::*;

  localparam int unsigned SUM_W = (COUNTER_WIDTH > DEPTH_W ? COUNTER_WIDTH : DEPTH_W) + 1;
  localparam logic [SUM_W-1:0] TOP = SUM_W'({COUNTER_WIDTH{1'b1}});

  logic [COUNTER_WIDTH-1:0] cnt_q [NUM_COUNTERS];
  logic [COUNTER_WIDTH-1:0] cnt_d [NUM_COUNTERS];
  logic [DEPTH_W-1:0]       inc   [NUM_COUNTERS];
  logic [SUM_W-1:0]         sum   [NUM_COUNTERS];
  logic [DEPTH_W-1:0]       one;
  logic [DEPTH_W-1:0]       flush_amt;

  assign one       = DEPTH_W'(1);
  assign flush_amt = flush_n_i;

  // Build the increment for each counter
  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      inc[i] = '0;
    end
    inc[CNT_ATTEMPTS]        = evt_i.attempt         ? one : '0;
    inc[CNT_ACCEPTED]        = evt_i.accepted        ? one : '0;
    inc[CNT_DISABLED]        = evt_i.disabled        ? one : '0;
    inc[CNT_FULL]            = evt_i.full            ? one : '0;
    inc[CNT_INVALID_FRAME]   = evt_i.invalid_frame   ? one : '0;
    inc[CNT_INVALID_PAYLOAD] = evt_i.invalid_payload ? one : '0;
    inc[CNT_DEQUEUED]        = evt_i.dequeued        ? one : '0;
    inc[CNT_DELIVERED]       = evt_i.delivered       ? one : '0;
    inc[CNT_FLUSHED]         = evt_i.flush           ? flush_amt : '0;
    inc[CNT_STALE]           = evt_i.stale_one       ? one :
                               evt_i.stale_flush     ? flush_amt : '0;
    inc[CNT_NOT_READY]       = evt_i.not_ready_one   ? one :
                               evt_i.not_ready_flush ? flush_amt : '0;
    inc[CNT_STOPPING]        = evt_i.stopping        ? one :
                               evt_i.stopping_flush  ? flush_amt : '0;
  end

  // Saturating add per counter; peak follows the depth after an accepted push
  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      sum[i]   = SUM_W'(cnt_q[i]) + SUM_W'(inc[i]);
      cnt_d[i] = (sum[i] > TOP) ? {COUNTER_WIDTH{1'b1}} : sum[i][COUNTER_WIDTH-1:0];
    end
    cnt_d[CNT_PEAK] = cnt_q[CNT_PEAK];
    if (evt_i.accepted && (SUM_W'(cnt_q[CNT_PEAK]) < SUM_W'(depth_i))) begin
      cnt_d[CNT_PEAK] = COUNTER_WIDTH'(depth_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // Read mux; indexes past the last counter read as zero
  assign rd_value_o = (rd_idx_i < CNT_IDX_W'(NUM_COUNTERS)) ? cnt_q[rd_idx_i] : '0;

  // The attempt counter never moves backward
  a_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[CNT_ATTEMPTS] >= $past(cnt_q[CNT_ATTEMPTS]))
    else $error("attempt counter decreased");

  // Every accepted push is also a push attempt
  a_accept_attempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.accepted |-> evt_i.attempt)
    else $error("accepted push without attempt");

  // Per-item and flush increments of the stale counter never coincide
  a_stale_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(evt_i.stale_one && evt_i.stale_flush))
    else $error("stale counted twice in one command");

endmodule

/* hw/rtl/frame_admission_queue.sv */
// Top level of the frame admission queue: command decode, admission checks,
// ring pointers, configuration registers and result register.
// Depends on fadq_pkg, fadq_ram and fadq_counters.
// Result: a command's result is in the output register in the cycle after its transfer.
// Throughput: one command per cycle unless stalled; pointers, session and counters update
// in one pass; the head entry is prefetched from entry RAM with a write-to-read bypass.
// Reset: queue empty, active session zero, counters zero, configuration at its
// defaults; entry RAM contents stay undefined and need no clearing pass.
module frame_admission_queue #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned TAG_WIDTH     = 16,
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // Configuration write channel
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [fadq_pkg::CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [fadq_pkg::CFG_DATA_W-1:0]            cfg_data_i,
  // Command channel
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic [fadq_pkg::CMD_W-1:0]                 command_i,
  input  logic                                       frame_valid_i,
  input  logic signed [fadq_pkg::CARD_W-1:0]         card_id_i,
  input  logic signed [fadq_pkg::SAMPLE_W-1:0]       sample_count_i,
  input  logic                                       freq_a_present_i,
  input  logic                                       freq_b_present_i,
  input  logic                                       payload_usable_i,
  input  logic [fadq_pkg::SESSION_W-1:0]             session_id_i,
  input  logic [TAG_WIDTH-1:0]                       frame_tag_i,
  input  logic                                       clear_reason_i,
  input  logic [fadq_pkg::CNT_IDX_W-1:0]             counter_index_i,
  // Result channel
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic [fadq_pkg::RESULT_W-1:0]              result_code_o,
  output logic [TAG_WIDTH-1:0]                       out_frame_tag_o,
  output logic [fadq_pkg::SESSION_W-1:0]             out_session_o,
  output logic [$clog2(CAPACITY+1)-1:0]              queue_depth_o,
  output logic [$clog2(CAPACITY+1)-1:0]              discarded_count_o,
  output logic [COUNTER_WIDTH-1:0]                   counter_value_o
);
  import fadq_pkg::*;

  localparam int unsigned DEPTH_W = $clog2(CAPACITY + 1);
  localparam int unsigned PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ENTRY_W = TAG_WIDTH + SESSION_W;
  localparam logic [DEPTH_W-1:0] CAP_D  = DEPTH_W'(CAPACITY);
  localparam logic [PTR_W-1:0]   LAST_P = PTR_W'(CAPACITY - 1);

  // Configuration registers
  logic              intake_q;
  logic [MASK_W-1:0] mask_q;
  logic              ready_q;
  logic              stop_q;

  // Queue state
  logic [PTR_W-1:0]     head_q, head_d;
  logic [DEPTH_W-1:0]   count_q, count_d;
  logic [SESSION_W-1:0] active_q, active_d;

  // Entry RAM and bypass
  logic               we;
  logic [PTR_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               byp_q;
  logic [ENTRY_W-1:0] byp_data_q;
  logic [ENTRY_W-1:0] head_entry;
  logic [TAG_WIDTH-1:0] head_tag;
  logic [SESSION_W-1:0] head_sess;

  // Push work signals
  logic               in_acc;
  logic               frame_bad;
  logic               disabled;
  logic [1:0]         pair;
  logic               sess_old;
  logic               sess_new;
  logic [DEPTH_W-1:0] cnt_eff;
  logic [PTR_W-1:0]   head_eff;
  logic [DEPTH_W:0]   tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   head_next;
  fadq_cnt_evt_t      evt;
  logic [COUNTER_WIDTH-1:0] rd_value;

  // Result register
  logic                 out_valid_q, out_valid_d;
  fadq_result_e         res_q, res_d;
  logic [TAG_WIDTH-1:0] tag_q, tag_d;
  logic [SESSION_W-1:0] sess_q, sess_d;
  logic [DEPTH_W-1:0]   depth_q;
  logic [DEPTH_W-1:0]   disc_q, disc_d;
  logic [COUNTER_WIDTH-1:0] cval_q, cval_d;

  // Handshakes: take a command whenever the result register frees up this cycle
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intake_q <= 1'b1;
      mask_q   <= '0;
      ready_q  <= 1'b0;
      stop_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (fadq_cfg_e'(cfg_index_i))
        CFG_INTAKE_ENABLED: intake_q <= cfg_data_i[0];
        CFG_CHANNEL_MASK:   mask_q   <= cfg_data_i[MASK_W-1:0];
        CFG_SERVICE_READY:  ready_q  <= cfg_data_i[0];
        CFG_STOPPING_FLAG:  stop_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Head entry: prefetched RAM word unless it was written in the previous cycle
  assign head_entry = byp_q ? byp_data_q : ram_rdata;
  assign head_tag   = head_entry[ENTRY_W-1 -: TAG_WIDTH];
  assign head_sess  = head_entry[SESSION_W-1:0];

  // Admission checks
  assign frame_bad = !frame_valid_i || card_id_i[CARD_W-1] ||
                     (sample_count_i == '0) || sample_count_i[SAMPLE_W-1] ||
                     !freq_a_present_i || !freq_b_present_i;
  assign pair      = mask_q[{card_id_i[1:0], 1'b0} +: 2];
  assign disabled  = !intake_q || card_id_i[2] || (pair == 2'b00);
  assign sess_old  = (session_id_i != '0) && (active_q != '0) && (session_id_i < active_q);
  assign sess_new  = (session_id_i != '0) && (session_id_i > active_q);

  // Ring arithmetic
  assign cnt_eff   = sess_new ? '0 : count_q;
  assign head_eff  = sess_new ? '0 : head_q;
  assign tail_sum  = (DEPTH_W + 1)'(head_eff) + (DEPTH_W + 1)'(cnt_eff);
  assign tail      = (tail_sum >= (DEPTH_W + 1)'(CAPACITY)) ?
                     PTR_W'(tail_sum - (DEPTH_W + 1)'(CAPACITY)) : PTR_W'(tail_sum);
  assign head_next = (head_q == LAST_P) ? '0 : head_q + PTR_W'(1);
  assign waddr     = tail;
  assign wdata     = {frame_tag_i, session_id_i};

  // Execute one command
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    active_d = active_q;
    we       = 1'b0;
    evt      = '0;
    res_d    = RC_DONE;
    tag_d    = '0;
    sess_d   = '0;
    disc_d   = '0;
    cval_d   = '0;
    if (in_acc) begin
      unique case (fadq_cmd_e'(command_i))
        CMD_PUSH: begin
          evt.attempt = 1'b1;
          priority if (frame_bad) begin
            res_d = RC_INVALID_FRAME;
            evt.invalid_frame = 1'b1;
          end else if (!payload_usable_i) begin
            res_d = RC_INVALID_PAYLOAD;
            evt.invalid_payload = 1'b1;
          end else if (stop_q) begin
            res_d = RC_STOPPING;
            evt.stopping = 1'b1;
          end else if (disabled) begin
            res_d = RC_DISABLED;
            evt.disabled = 1'b1;
          end else if (!ready_q) begin
            res_d = RC_NOT_READY;
            evt.not_ready_one = 1'b1;
          end else if (sess_old) begin
            res_d = RC_STALE;
            evt.stale_one = 1'b1;
          end else begin
            // A newer session flushes before the capacity check
            if (sess_new) begin
              evt.flush       = 1'b1;
              evt.stale_flush = 1'b1;
              disc_d          = count_q;
              active_d        = session_id_i;
            end
            head_d = head_eff;
            if (cnt_eff == CAP_D) begin
              res_d    = RC_FULL;
              evt.full = 1'b1;
              count_d  = cnt_eff;
            end else begin
              we           = 1'b1;
              count_d      = cnt_eff + DEPTH_W'(1);
              res_d        = RC_ACCEPTED;
              evt.accepted = 1'b1;
            end
          end
        end
        CMD_POP: begin
          if (count_q == '0) begin
            res_d = RC_EMPTY;
          end else begin
            head_d       = head_next;
            count_d      = count_q - DEPTH_W'(1);
            evt.dequeued = 1'b1;
            priority if ((head_sess != '0) && (head_sess != active_q)) begin
              res_d = RC_STALE;
              evt.stale_one = 1'b1;
            end else if (!ready_q) begin
              res_d = RC_NOT_READY;
              evt.not_ready_one = 1'b1;
            end else begin
              res_d         = RC_DELIVERED;
              evt.delivered = 1'b1;
              tag_d         = head_tag;
              sess_d        = head_sess;
            end
          end
        end
        CMD_BEGIN: begin
          evt.flush       = 1'b1;
          evt.stale_flush = 1'b1;
          disc_d          = count_q;
          count_d         = '0;
          head_d          = '0;
          active_d        = session_id_i;
        end
        CMD_CLEAR: begin
          evt.flush           = 1'b1;
          evt.not_ready_flush = clear_reason_i;
          evt.stopping_flush  = !clear_reason_i;
          disc_d              = count_q;
          count_d             = '0;
          head_d              = '0;
        end
        CMD_READ: begin
          cval_d = rd_value;
        end
        default: ;
      endcase
    end
  end

  // Queue state and read bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      active_q <= '0;
      byp_q    <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      active_q <= active_d;
      byp_q    <= we && (waddr == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
  end

  fadq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  fadq_counters #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .DEPTH_W       (DEPTH_W)
  ) u_counters (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt),
    .flush_n_i  (count_q),
    .depth_i    (count_d),
    .rd_idx_i   (counter_index_i),
    .rd_value_o (rd_value)
  );

  // Result register: load on transfer in, hold while stalled
  assign out_valid_d = in_acc ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q   <= res_d;
      tag_q   <= tag_d;
      sess_q  <= sess_d;
      depth_q <= count_d;
      disc_q  <= disc_d;
      cval_q  <= cval_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_code_o     = res_q;
  assign out_frame_tag_o   = tag_q;
  assign out_session_o     = sess_q;
  assign queue_depth_o     = depth_q;
  assign discarded_count_o = disc_q;
  assign counter_value_o   = cval_q;

  // Fill level stays within capacity and head inside the ring
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CAP_D) && (head_q <= LAST_P))
    else $error("queue pointer or count out of range");

  // Every command transfer produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("command transfer without result");

  // An accepted push always leaves a nonempty queue
  a_accept_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q == RC_ACCEPTED)) |-> (depth_q != '0))
    else $error("accepted push reported empty queue");

  // Flushes only come from push, begin session or clear
  a_disc_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (disc_q != '0)) |->
      ((res_q == RC_ACCEPTED) || (res_q == RC_FULL) || (res_q == RC_DONE)))
    else $error("discard reported for a non-flushing command");

  // A write never lands on the head while entries are queued ahead of it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && (cnt_eff != '0)) |-> (waddr != head_eff))
    else $error("push overwrote a queued entry");

endmodule

/* verif/tb_frame_admission_queue.sv */
// Self-checking testbench for frame_admission_queue: directed admission cases, then random
// command traffic under several settings, idle patterns and a long output hold-off.
// Depends on fadq_pkg and frame_admission_queue; results are checked by a shadow queue model.
module tb_frame_admission_queue;
  import fadq_pkg::*;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned TAG_WIDTH     = 16;
  localparam int unsigned COUNTER_WIDTH = 32;
  localparam int unsigned DEPTH_W       = $clog2(CAPACITY + 1);

  localparam logic [CMD_W-1:0]     CMD_UNUSED_TOP     = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX   = 4'd15;
  localparam logic [CNT_IDX_W-1:0] CNT_INDEX_PAST_END = 4'd15;

  localparam int unsigned ITEMS_PER_PHASE = 115;
  localparam int unsigned LONG_HOLD_OFF   = 150;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned MAX_REPORTS     = 40;

  typedef struct {
    logic [CMD_W-1:0]           opcode;
    logic                       frame_valid;
    logic signed [CARD_W-1:0]   card_id;
    logic signed [SAMPLE_W-1:0] sample_count;
    logic                       freq_a;
    logic                       freq_b;
    logic                       payload_usable;
    logic [SESSION_W-1:0]       session_id;
    logic [TAG_WIDTH-1:0]       frame_tag;
    logic                       clear_reason;
    logic [CNT_IDX_W-1:0]       counter_index;
  } command_t;

  typedef struct {
    fadq_result_e             code;
    logic [TAG_WIDTH-1:0]     tag;
    logic [SESSION_W-1:0]     session;
    logic [DEPTH_W-1:0]       depth;
    logic [DEPTH_W-1:0]       discarded;
    logic [COUNTER_WIDTH-1:0] counter;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [CMD_W-1:0] command_i;
  logic frame_valid_i;
  logic signed [CARD_W-1:0] card_id_i;
  logic signed [SAMPLE_W-1:0] sample_count_i;
  logic freq_a_present_i;
  logic freq_b_present_i;
  logic payload_usable_i;
  logic [SESSION_W-1:0] session_id_i;
  logic [TAG_WIDTH-1:0] frame_tag_i;
  logic clear_reason_i;
  logic [CNT_IDX_W-1:0] counter_index_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [RESULT_W-1:0] result_code_o;
  logic [TAG_WIDTH-1:0] out_frame_tag_o;
  logic [SESSION_W-1:0] out_session_o;
  logic [DEPTH_W-1:0] queue_depth_o;
  logic [DEPTH_W-1:0] discarded_count_o;
  logic [COUNTER_WIDTH-1:0] counter_value_o;

  // Shadow copy of the queue, its settings and its statistics
  logic                     shadow_intake;
  logic [MASK_W-1:0]        shadow_mask;
  logic                     shadow_ready;
  logic                     shadow_stopping;
  logic [TAG_WIDTH-1:0]     shadow_tags [CAPACITY];
  logic [SESSION_W-1:0]     shadow_sessions [CAPACITY];
  logic [3:0]               shadow_head;
  int unsigned              shadow_count;
  logic [SESSION_W-1:0]     shadow_active;
  logic [COUNTER_WIDTH-1:0] shadow_stats [NUM_COUNTERS];

  outcome_t    outcomes_due[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_left;

  frame_admission_queue #(
    .CAPACITY     (CAPACITY),
    .TAG_WIDTH    (TAG_WIDTH),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .frame_valid_i    (frame_valid_i),
    .card_id_i        (card_id_i),
    .sample_count_i   (sample_count_i),
    .freq_a_present_i (freq_a_present_i),
    .freq_b_present_i (freq_b_present_i),
    .payload_usable_i (payload_usable_i),
    .session_id_i     (session_id_i),
    .frame_tag_i      (frame_tag_i),
    .clear_reason_i   (clear_reason_i),
    .counter_index_i  (counter_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_code_o    (result_code_o),
    .out_frame_tag_o  (out_frame_tag_o),
    .out_session_o    (out_session_o),
    .queue_depth_o    (queue_depth_o),
    .discarded_count_o(discarded_count_o),
    .counter_value_o  (counter_value_o)
  );

  // Clock generation
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  function automatic void reset_shadow();
    shadow_intake   = 1'b1;
    shadow_mask     = '0;
    shadow_ready    = 1'b0;
    shadow_stopping = 1'b0;
    shadow_head     = '0;
    shadow_count    = 0;
    shadow_active   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_tags[i]     = '0;
      shadow_sessions[i] = '0;
    end
    for (int i = 0; i < NUM_COUNTERS; i++) shadow_stats[i] = '0;
  endfunction

  function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [CFG_DATA_W-1:0] data);
    unique case (idx)
      CFG_INTAKE_ENABLED: shadow_intake = data[0];
      CFG_CHANNEL_MASK:   shadow_mask = data;
      CFG_SERVICE_READY:  shadow_ready = data[0];
      CFG_STOPPING_FLAG:  shadow_stopping = data[0];
      default: ;
    endcase
  endfunction

  // Saturating statistics increment
  function automatic void bump_stat(input fadq_cnt_e idx, input int unsigned n);
    logic [COUNTER_WIDTH:0] sum;
    sum = {1'b0, shadow_stats[idx]} + (COUNTER_WIDTH + 1)'(n);
    shadow_stats[idx] = sum[COUNTER_WIDTH] ? '1 : sum[COUNTER_WIDTH-1:0];
  endfunction

  function automatic int unsigned flush_entries();
    int unsigned n;
    n = shadow_count;
    shadow_count = 0;
    shadow_head = '0;
    bump_stat(CNT_FLUSHED, n);
    return n;
  endfunction

  // Apply one command to the shadow queue and return the result it produces
  function automatic outcome_t queue_outcome(input command_t c);
    outcome_t    o;
    logic [3:0]  card_bits;
    logic [1:0]  pair;
    logic [3:0]  tail;
    int unsigned n;
    o.code = RC_DONE;
    o.tag = '0;
    o.session = '0;
    o.discarded = '0;
    o.counter = '0;
    card_bits = c.card_id;
    unique case (c.opcode)
      CMD_PUSH: begin
        bump_stat(CNT_ATTEMPTS, 1);
        if (!c.frame_valid || card_bits[3] || c.sample_count == '0 || c.sample_count[15] ||
            !c.freq_a || !c.freq_b) begin
          o.code = RC_INVALID_FRAME;
          bump_stat(CNT_INVALID_FRAME, 1);
        end else if (!c.payload_usable) begin
          o.code = RC_INVALID_PAYLOAD;
          bump_stat(CNT_INVALID_PAYLOAD, 1);
        end else if (shadow_stopping) begin
          o.code = RC_STOPPING;
          bump_stat(CNT_STOPPING, 1);
        end else begin
          // cards 4 and up have no channel bits
          pair = card_bits[2] ? 2'b00 : shadow_mask[{card_bits[1:0], 1'b0} +: 2];
          if (!shadow_intake || pair == 2'b00) begin
            o.code = RC_DISABLED;
            bump_stat(CNT_DISABLED, 1);
          end else if (!shadow_ready) begin
            o.code = RC_NOT_READY;
            bump_stat(CNT_NOT_READY, 1);
          end else if (c.session_id != '0 && shadow_active != '0 &&
                       c.session_id < shadow_active) begin
            o.code = RC_STALE;
            bump_stat(CNT_STALE, 1);
          end else begin
            // a newer session drops everything queued for the old one
            if (c.session_id != '0 && c.session_id > shadow_active) begin
              n = flush_entries();
              o.discarded = DEPTH_W'(n);
              bump_stat(CNT_STALE, n);
              shadow_active = c.session_id;
            end
            if (shadow_count >= CAPACITY) begin
              o.code = RC_FULL;
              bump_stat(CNT_FULL, 1);
            end else begin
              tail = shadow_head + 4'(shadow_count);
              shadow_tags[tail] = c.frame_tag;
              shadow_sessions[tail] = c.session_id;
              shadow_count++;
              o.code = RC_ACCEPTED;
              bump_stat(CNT_ACCEPTED, 1);
              if (shadow_stats[CNT_PEAK] < COUNTER_WIDTH'(shadow_count)) begin
                shadow_stats[CNT_PEAK] = COUNTER_WIDTH'(shadow_count);
              end
            end
          end
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          o.code = RC_EMPTY;
        end else begin
          tail = shadow_head;
          shadow_head = shadow_head + 4'd1;
          shadow_count--;
          bump_stat(CNT_DEQUEUED, 1);
          if (shadow_sessions[tail] != '0 && shadow_sessions[tail] != shadow_active) begin
            o.code = RC_STALE;
            bump_stat(CNT_STALE, 1);
          end else if (!shadow_ready) begin
            o.code = RC_NOT_READY;
            bump_stat(CNT_NOT_READY, 1);
          end else begin
            o.code = RC_DELIVERED;
            bump_stat(CNT_DELIVERED, 1);
            o.tag = shadow_tags[tail];
            o.session = shadow_sessions[tail];
          end
        end
      end
      CMD_BEGIN: begin
        n = flush_entries();
        o.discarded = DEPTH_W'(n);
        bump_stat(CNT_STALE, n);
        shadow_active = c.session_id;
      end
      CMD_CLEAR: begin
        n = flush_entries();
        o.discarded = DEPTH_W'(n);
        if (c.clear_reason) begin
          bump_stat(CNT_NOT_READY, n);
        end else begin
          bump_stat(CNT_STOPPING, n);
        end
      end
      CMD_READ: begin
        if (c.counter_index < NUM_COUNTERS) o.counter = shadow_stats[c.counter_index];
      end
      default: ;
    endcase
    o.depth = DEPTH_W'(shadow_count);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Command builders
  // ---------------------------------------------------------------------------

  function automatic command_t make_op(input logic [CMD_W-1:0] op);
    command_t c;
    c.opcode = op;
    c.frame_valid = 1'b0;
    c.card_id = '0;
    c.sample_count = '0;
    c.freq_a = 1'b0;
    c.freq_b = 1'b0;
    c.payload_usable = 1'b0;
    c.session_id = '0;
    c.frame_tag = '0;
    c.clear_reason = 1'b0;
    c.counter_index = '0;
    return c;
  endfunction

  // Well-formed push: every validity flag set
  function automatic command_t make_push(input logic [CARD_W-1:0] card,
                                         input logic [SAMPLE_W-1:0] samples,
                                         input logic [SESSION_W-1:0] session,
                                         input logic [TAG_WIDTH-1:0] tag);
    command_t c;
    c = make_op(CMD_PUSH);
    c.frame_valid = 1'b1;
    c.card_id = card;
    c.sample_count = samples;
    c.freq_a = 1'b1;
    c.freq_b = 1'b1;
    c.payload_usable = 1'b1;
    c.session_id = session;
    c.frame_tag = tag;
    return c;
  endfunction

  function automatic command_t make_read(input logic [CNT_IDX_W-1:0] idx);
    command_t c;
    c = make_op(CMD_READ);
    c.counter_index = idx;
    return c;
  endfunction

  // Mostly the current session, sometimes zero, newer, older or anywhere
  function automatic logic [SESSION_W-1:0] pick_session();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return shadow_active;
    if (r < 80) return '0;
    if (r < 86) return shadow_active + 64'd1;
    if (r < 96) return shadow_active - 64'd1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic command_t random_push();
    command_t c;
    c = make_push(($urandom_range(0, 9) == 0) ? 4'($urandom_range(4, 7)) :
                                                4'($urandom_range(0, 3)),
                  16'($urandom_range(1, 32767)), pick_session(), 16'($urandom()));
    // occasionally break one of the checks
    c.frame_valid    = $urandom_range(0, 99) >= 3;
    c.freq_a         = $urandom_range(0, 99) >= 3;
    c.freq_b         = $urandom_range(0, 99) >= 3;
    c.payload_usable = $urandom_range(0, 99) >= 3;
    if ($urandom_range(0, 99) < 3) c.card_id = 4'($urandom_range(8, 15));
    if ($urandom_range(0, 99) < 3) c.sample_count = 16'($urandom_range(32768, 65536));
    return c;
  endfunction

  function automatic command_t random_noise();
    command_t c;
    c.opcode = 3'($urandom());
    c.frame_valid = 1'($urandom());
    c.card_id = 4'($urandom());
    c.sample_count = 16'($urandom());
    c.freq_a = 1'($urandom());
    c.freq_b = 1'($urandom());
    c.payload_usable = 1'($urandom());
    c.session_id = {$urandom(), $urandom()};
    c.frame_tag = 16'($urandom());
    c.clear_reason = 1'($urandom());
    c.counter_index = 4'($urandom());
    return c;
  endfunction

  function automatic command_t next_random_command(input int unsigned push_pct);
    command_t    c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      c = random_push();
    end else if (r < push_pct + 25) begin
      c = make_op(CMD_POP);
    end else if (r < push_pct + 31) begin
      c = make_read(4'($urandom()));
    end else if (r < push_pct + 34) begin
      c = make_op(CMD_BEGIN);
      c.session_id = $urandom_range(0, 1) ? 64'($urandom_range(0, 20)) :
                                            {$urandom(), $urandom()};
    end else if (r < push_pct + 37) begin
      c = make_op(CMD_CLEAR);
      c.clear_reason = 1'($urandom());
    end else begin
      c = random_noise();
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers and checker
  // ---------------------------------------------------------------------------

  // Offer one command and record its predicted result on transfer
  task automatic send_command(input command_t c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    command_i        = c.opcode;
    frame_valid_i    = c.frame_valid;
    card_id_i        = c.card_id;
    sample_count_i   = c.sample_count;
    freq_a_present_i = c.freq_a;
    freq_b_present_i = c.freq_b;
    payload_usable_i = c.payload_usable;
    session_id_i     = c.session_id;
    frame_tag_i      = c.frame_tag;
    clear_reason_i   = c.clear_reason;
    counter_index_i  = c.counter_index;
    do @(posedge clk_i); while (in_stall_o);
    outcomes_due.insert(outcomes_due.size(), queue_outcome(c));
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Single-bit settings ride with random upper bits
  function automatic logic [CFG_DATA_W-1:0] flag_byte(input logic flag);
    return {7'($urandom()), flag};
  endfunction

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
    end
  endtask

  task automatic check_outcome();
    outcome_t want;
    if (outcomes_due.size() == 0) begin
      report_mismatch("result with nothing pending", 64'(result_code_o), '0);
    end else begin
      want = outcomes_due[0];
      outcomes_due.delete(0);
      if (result_code_o !== want.code) begin
        report_mismatch("result_code", 64'(result_code_o), 64'(want.code));
      end
      if (out_frame_tag_o !== want.tag) begin
        report_mismatch("out_frame_tag", 64'(out_frame_tag_o), 64'(want.tag));
      end
      if (out_session_o !== want.session) begin
        report_mismatch("out_session", out_session_o, want.session);
      end
      if (queue_depth_o !== want.depth) begin
        report_mismatch("queue_depth", 64'(queue_depth_o), 64'(want.depth));
      end
      if (discarded_count_o !== want.discarded) begin
        report_mismatch("discarded_count", 64'(discarded_count_o), 64'(want.discarded));
      end
      if (counter_value_o !== want.counter) begin
        report_mismatch("counter_value", 64'(counter_value_o), 64'(want.counter));
      end
    end
  endtask

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_outcome();
  end

  // Result side stall: long hold-off first, otherwise random
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i = 1'b1;
        hold_off_left--;
      end else begin
        out_stall_i = $urandom_range(0, 99) < recv_idle_pct;
      end
    end
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Each rejection reason except a full queue, field extremes and the corner cases of pop and read
  task automatic test_directed_cases();
    command_t c;
    // reset settings: intake on, no channels, service down
    send_command(make_read(CNT_ACCEPTED));
    send_command(make_op(CMD_POP));
    c = make_push(4'd0, 16'd10, '0, 16'd1);
    c.frame_valid = 1'b0;
    send_command(c);
    send_command(make_push(4'h8, 16'd10, '0, 16'd2));   // most negative card
    send_command(make_push(4'd1, 16'h8000, '0, 16'd3)); // most negative sample count
    send_command(make_push(4'd1, 16'd0, '0, 16'd4));
    c = make_push(4'd2, 16'd10, '0, 16'd5);
    c.freq_a = 1'b0;
    send_command(c);
    c = make_push(4'd2, 16'd10, '0, 16'd6);
    c.freq_b = 1'b0;
    send_command(c);
    c = make_push(4'd2, 16'd10, '0, 16'd7);
    c.payload_usable = 1'b0;
    send_command(c);
    send_command(make_push(4'd0, 16'd10, '0, 16'd8));   // no channel enabled
    drain_results();
    write_register(CFG_CHANNEL_MASK, 8'hFF);
    write_register(CFG_STOPPING_FLAG, 8'h01);
    write_register(CFG_UNUSED_INDEX, 8'hFF);
    send_command(make_push(4'd0, 16'd10, '0, 16'd9));
    drain_results();
    write_register(CFG_STOPPING_FLAG, 8'h00);
    send_command(make_push(4'd7, 16'd10, '0, 16'd10));  // card without channel bits
    send_command(make_push(4'd3, 16'd10, '0, 16'd11));  // service still down
    drain_results();
    write_register(CFG_SERVICE_READY, 8'h01);
    send_command(make_push(4'd0, 16'd1, '0, 16'h0000));
    send_command(make_push(4'd3, 16'h7FFF, '1, 16'hFFFF)); // newest session flushes
    send_command(make_push(4'd1, 16'd10, 64'd5, 16'd12)); // older session
    send_command(make_push(4'd1, 16'd10, '0, 16'h1234)); // session zero is never stale
    drain_results();
    write_register(CFG_SERVICE_READY, 8'h00);
    send_command(make_op(CMD_POP));
    drain_results();
    write_register(CFG_SERVICE_READY, 8'h01);
    send_command(make_op(CMD_POP));
    send_command(make_read(CNT_INDEX_PAST_END));
    send_command(make_read(CNT_DELIVERED));
    send_command(make_op(CMD_UNUSED_TOP));
    c = make_op(CMD_BEGIN);
    send_command(c);
    send_command(make_push(4'd2, 16'd100, '0, 16'd13));
    c = make_op(CMD_CLEAR);
    c.clear_reason = 1'b1;
    send_command(c);
  endtask

  task automatic configure_phase(input int unsigned phase);
    unique case (phase)
      0: begin
        write_register(CFG_INTAKE_ENABLED, flag_byte(1'b1));
        write_register(CFG_CHANNEL_MASK, 8'hFF);
        write_register(CFG_SERVICE_READY, flag_byte(1'b1));
        write_register(CFG_STOPPING_FLAG, flag_byte(1'b0));
      end
      1: begin
        write_register(CFG_INTAKE_ENABLED, flag_byte(1'b1));
        write_register(CFG_CHANNEL_MASK, 8'($urandom()));
        write_register(CFG_SERVICE_READY, flag_byte(1'b1));
        write_register(CFG_STOPPING_FLAG, flag_byte(1'b0));
      end
      2: begin
        write_register(CFG_INTAKE_ENABLED, flag_byte($urandom_range(0, 3) != 0));
        write_register(CFG_CHANNEL_MASK, 8'($urandom()));
        write_register(CFG_SERVICE_READY, flag_byte($urandom_range(0, 3) != 0));
        write_register(CFG_STOPPING_FLAG, flag_byte($urandom_range(0, 9) == 0));
      end
      default: begin
        write_register(CFG_INTAKE_ENABLED, flag_byte(1'b1));
        write_register(CFG_CHANNEL_MASK, 8'h01 << $urandom_range(0, 7));
        write_register(CFG_SERVICE_READY, flag_byte(1'b1));
        write_register(CFG_STOPPING_FLAG, flag_byte(1'b0));
      end
    endcase
  endtask

  // Random traffic over four settings with the given idle rates
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned phase = 0; phase < 4; phase++) begin
      drain_results();
      configure_phase(phase);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_command(next_random_command((phase == 0) ? 60 : 45));
      end
    end
  endtask

  // Hold the result side off while pushes keep coming: the queue fills and input stalls
  task automatic test_backpressure_fill();
    drain_results();
    configure_phase(0);
    send_idle_pct = 0;
    hold_off_left = LONG_HOLD_OFF;
    for (int unsigned n = 0; n < CAPACITY + 4; n++) begin
      send_command(make_push(4'($urandom_range(0, 3)), 16'($urandom_range(1, 32767)), '0,
                             16'($urandom())));
    end
    for (int unsigned n = 0; n < CAPACITY + 4; n++) send_command(make_op(CMD_POP));
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    command_i        = '0;
    frame_valid_i    = 1'b0;
    card_id_i        = '0;
    sample_count_i   = '0;
    freq_a_present_i = 1'b0;
    freq_b_present_i = 1'b0;
    payload_usable_i = 1'b0;
    session_id_i     = '0;
    frame_tag_i      = '0;
    clear_reason_i   = 1'b0;
    counter_index_i  = '0;
    error_count      = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_off_left    = 0;
    reset_shadow();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_traffic(27, 48);
    test_random_traffic(48, 27);
    test_random_traffic(0, 0);
    test_backpressure_fill();
    drain_results();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
